@@ hw/rtl/pngu_pkg.sv @@
package pngu_pkg;

   localparam int MAX_ROW_BYTES = 8192;
   localparam int MAX_BPP       = 4;
   localparam int ROWS_LIMIT    = 32768;

   localparam int ADDR_W   = $clog2(MAX_ROW_BYTES);
   localparam int COL_W    = $clog2(MAX_ROW_BYTES + 1);
   localparam int BPP_W    = 3;
   localparam int BPP_IDX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
   localparam int ROWCFG_W = 16;
   localparam int ROWIDX_W = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYTES_PER_PIXEL = 2'd0,
      CSR_ROW_BYTES       = 2'd1,
      CSR_IMAGE_ROWS      = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   localparam logic [7:0] FILT_MAX_CODE = 8'd4;

   // one filtered byte on its way from the request side to reconstruction
   typedef struct packed {
      logic [7:0]        data_byte;
      filter_type        filter;
      logic              first_row;
      logic [ADDR_W-1:0] pos;
      logic              left_ok;
      logic              bad;
      logic              last;
   } item_type;

endpackage

@@ hw/rtl/pngu_recon.sv @@
module pngu_recon
   import pngu_pkg::*;
(
   input  logic                 clock,
   input  logic                 advance,
   input  item_type             item,
   input  logic [7:0]           up_byte,
   input  logic [BPP_IDX_W-1:0] bpp_idx,
   output logic [7:0]           value
);

   logic [7:0] left_ff [MAX_BPP];
   logic [7:0] upleft_ff [MAX_BPP];
   logic [7:0] a, b, c, pred, paeth_pred;
   logic [8:0] sum_ab;
   logic [9:0] pa, pb, pc;

   function automatic logic [9:0] abs10(input logic signed [9:0] v);
      abs10 = v[9] ? 10'(-v) : v;
   endfunction

   // neighbours read as zero at the left edge and on the first row
   assign b = item.first_row ? 8'd0 : up_byte;
   assign a = item.left_ok ? left_ff[bpp_idx] : 8'd0;
   assign c = (item.left_ok && !item.first_row) ? upleft_ff[bpp_idx] : 8'd0;

   assign sum_ab = {1'b0, a} + {1'b0, b};
   assign pa = abs10(10'({2'b00, b}) - 10'({2'b00, c}));
   assign pb = abs10(10'({2'b00, a}) - 10'({2'b00, c}));
   assign pc = abs10(10'({1'b0, sum_ab}) - 10'({1'b0, c, 1'b0}));

   always_comb begin
      if (pa <= pb && pa <= pc) begin
         paeth_pred = a;
      end else if (pb <= pc) begin
         paeth_pred = b;
      end else begin
         paeth_pred = c;
      end
   end

   always_comb begin
      case (item.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = sum_ab[8:1];
         FILT_PAETH: pred = paeth_pred;
         default:    pred = 8'd0;
      endcase
   end

   assign value = item.bad ? 8'd0 : 8'(item.data_byte + pred);

   // windows of the last reconstructed and prior-row bytes
   always_ff @(posedge clock) begin
      if (advance && !item.bad) begin
         for (int k = MAX_BPP - 1; k > 0; k--) begin
            left_ff[k]   <= left_ff[k-1];
            upleft_ff[k] <= upleft_ff[k-1];
         end
         left_ff[0]   <= value;
         upleft_ff[0] <= b;
      end
   end

endmodule

@@ hw/rtl/png_scanline_unfilter_unit.sv @@
// png scanline unfilter
// request channel (req_valid/req_ready, req_data_byte) takes the inflated
// stream one byte per request: each row is a filter-type byte followed by
// row_bytes filtered bytes. the filter byte gives no response; each data
// byte gives one response (rsp_pixel_byte, rsp_last on the final byte of
// the image). a filter type above 4 gives one response with rsp_bad_filter
// set, after which requests are still taken but answered with nothing.
// csr channel writes bytes_per_pixel, row_bytes and image_rows by index;
// write it only while no request is in flight. csr_ready is always high.
// throughput: one request per cycle, sustained while the response side does not stall.
// a data byte is taken into the read stage, where the line buffer is read, then
// reconstructed and written back as it moves into the output register.
// a stall on the response side holds the output register and then the
// read stage; req_ready drops only when both are full.
// reset: synchronous, clears control state and the configuration registers to their
// defaults; the line buffer is not cleared and is filled by the first row.
module png_scanline_unfilter_unit
   import pngu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_bad_filter,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [BPP_W-1:0]    bpp_ff;
   logic [COL_W-1:0]    row_bytes_ff;
   logic [ROWCFG_W-1:0] image_rows_ff;

   // row tracking, updated as each request is taken while not halted
   logic [COL_W-1:0]    column_ff, column_in;
   logic [ROWIDX_W-1:0] row_index_ff, row_index_in;
   filter_type          row_filter_ff, row_filter_in;
   logic                first_row_ff, first_row_in;
   logic                halted_ff, halted_in;

   // read stage and output register
   logic                s1_valid_ff, s1_valid_in;
   item_type            s1_ff, s1_in;
   logic                out_valid_ff;
   logic [7:0]          out_pixel_ff;
   logic                out_bad_ff;
   logic                out_last_ff;

   // line buffer of the prior row
   logic [7:0]          prior_row [MAX_ROW_BYTES];
   logic [7:0]          rd_data_ff;

   logic                req_accept, s1_advance, out_free;
   logic [BPP_W-1:0]    bpp_eff;
   logic [COL_W-1:0]    rb_eff;
   logic [ROWCFG_W:0]   rows_eff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                row_end, image_end;
   logic [7:0]          value;

   assign csr_ready = 1'b1;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   // registers out of range saturate
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_BPP)) begin
         bpp_eff = BPP_W'(MAX_BPP);
      end else begin
         bpp_eff = bpp_ff;
      end
      if (row_bytes_ff == '0) begin
         rb_eff = COL_W'(1);
      end else if (row_bytes_ff > COL_W'(MAX_ROW_BYTES)) begin
         rb_eff = COL_W'(MAX_ROW_BYTES);
      end else begin
         rb_eff = row_bytes_ff;
      end
      if (image_rows_ff == '0) begin
         rows_eff = (ROWCFG_W+1)'(1);
      end else if (image_rows_ff > ROWCFG_W'(ROWS_LIMIT)) begin
         rows_eff = (ROWCFG_W+1)'(ROWS_LIMIT);
      end else begin
         rows_eff = {1'b0, image_rows_ff};
      end
   end

   // position of the data byte within the row
   assign rd_addr   = ADDR_W'(column_ff - COL_W'(1));
   assign row_end   = column_ff >= rb_eff;
   assign image_end = ((ROWCFG_W+1)'(row_index_ff) + (ROWCFG_W+1)'(1)) >= rows_eff;

   always_comb begin
      column_in     = column_ff;
      row_index_in  = row_index_ff;
      row_filter_in = row_filter_ff;
      first_row_in  = first_row_ff;
      halted_in     = halted_ff;
      s1_valid_in   = s1_advance ? 1'b0 : s1_valid_ff;
      s1_in         = s1_ff;
      if (req_accept && !halted_ff) begin
         if (column_ff == '0) begin
            if (req_data_byte > FILT_MAX_CODE) begin
               // bad filter: one error response, then silence
               halted_in       = 1'b1;
               s1_valid_in     = 1'b1;
               s1_in           = '0;
               s1_in.bad       = 1'b1;
            end else begin
               row_filter_in = filter_type'(req_data_byte[2:0]);
               column_in     = COL_W'(1);
            end
         end else begin
            s1_valid_in     = 1'b1;
            s1_in.data_byte = req_data_byte;
            s1_in.filter    = row_filter_ff;
            s1_in.first_row = first_row_ff;
            s1_in.pos       = rd_addr;
            s1_in.left_ok   = (COL_W'(rd_addr) >= COL_W'(bpp_eff));
            s1_in.bad       = 1'b0;
            s1_in.last      = row_end && image_end;
            if (row_end) begin
               column_in = '0;
               if (image_end) begin
                  row_index_in = '0;
                  first_row_in = 1'b1;
               end else begin
                  row_index_in = row_index_ff + ROWIDX_W'(1);
                  first_row_in = 1'b0;
               end
            end else begin
               column_in = column_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= BPP_W'(MAX_BPP);
         row_bytes_ff  <= COL_W'(MAX_ROW_BYTES);
         image_rows_ff <= ROWCFG_W'(1);
         column_ff     <= '0;
         row_index_ff  <= '0;
         row_filter_ff <= FILT_NONE;
         first_row_ff  <= 1'b1;
         halted_ff     <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_BYTES_PER_PIXEL: bpp_ff        <= csr_data[BPP_W-1:0];
               CSR_ROW_BYTES:       row_bytes_ff  <= csr_data[COL_W-1:0];
               CSR_IMAGE_ROWS:      image_rows_ff <= csr_data[ROWCFG_W-1:0];
               default: ;
            endcase
         end
         column_ff     <= column_in;
         row_index_ff  <= row_index_in;
         row_filter_ff <= row_filter_in;
         first_row_ff  <= first_row_in;
         halted_ff     <= halted_in;
         s1_valid_ff   <= s1_valid_in;
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_advance) begin
         out_pixel_ff <= value;
         out_bad_ff   <= s1_ff.bad;
         out_last_ff  <= s1_ff.last;
      end
   end

   // line buffer: read as a request is taken, write back as the byte retires.
   // the same entry is read again only a row later, behind a filter byte,
   // so a read never meets the write of its own entry in flight
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= prior_row[rd_addr];
      end
      if (s1_advance && !s1_ff.bad) begin
         prior_row[s1_ff.pos] <= value;
      end
   end

   pngu_recon u_recon (
      .clock   (clock),
      .advance (s1_advance),
      .item    (s1_ff),
      .up_byte (rd_data_ff),
      .bpp_idx (BPP_IDX_W'(bpp_eff - BPP_W'(1))),
      .value   (value)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_byte = out_pixel_ff;
   assign rsp_bad_filter = out_bad_ff;
   assign rsp_last       = out_last_ff;

   // once halted the block stays halted until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");

   // an error item in the read stage means the block is halted
   a_bad_halts: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.bad) |-> halted_ff)
      else $error("bad filter item without halt");

   // a filter byte never loads the read stage
   a_filter_no_item: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !halted_ff && column_ff == '0 && req_data_byte <= FILT_MAX_CODE
       && (!s1_valid_ff || s1_advance)) |=> !s1_valid_ff)
      else $error("filter byte produced an item");

   // error responses carry no pixel and no last mark
   a_bad_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_filter) |-> (rsp_pixel_byte == 8'd0 && !rsp_last))
      else $error("error response with payload");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import pngu_pkg::*;

   // what one reconstructed byte should look like on the response side
   typedef struct packed {
      logic [7:0] pixel;
      logic       bad;
      logic       is_last;
   } pixel_result_type;

   // reconstruction predictor plus the queue of pixels still owed by the block
   class unfilter_scoreboard_type;
      logic [BPP_W-1:0]    bpp_reg;
      logic [13:0]         row_bytes_reg;
      logic [15:0]         rows_reg;
      logic [7:0]          line_buf [MAX_ROW_BYTES];
      logic [7:0]          left_win [MAX_BPP];
      logic [7:0]          upleft_win [MAX_BPP];
      int unsigned         column;
      int unsigned         row_idx;
      filter_type          row_filter;
      bit                  first_row;
      bit                  halted;
      pixel_result_type    owed_pixels[$];
      int                  errors;
      int                  checked;

      function new();
         bpp_reg       = 3'd4;
         row_bytes_reg = 14'd8192;
         rows_reg      = 16'd1;
         left_win      = '{default: 8'h00};
         upleft_win    = '{default: 8'h00};
         column        = 0;
         row_idx       = 0;
         row_filter    = FILT_NONE;
         first_row     = 1'b1;
         halted        = 1'b0;
         errors        = 0;
         checked       = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] val);
         case (idx)
            CSR_BYTES_PER_PIXEL: bpp_reg = val[2:0];
            CSR_ROW_BYTES:       row_bytes_reg = val[13:0];
            CSR_IMAGE_ROWS:      rows_reg = val;
            default: ;
         endcase
      endfunction

      function int unsigned pixel_bytes();
         if (bpp_reg < 1) return 1;
         if (bpp_reg > MAX_BPP) return MAX_BPP;
         return bpp_reg;
      endfunction

      function int unsigned row_len();
         if (row_bytes_reg < 1) return 1;
         if (row_bytes_reg > MAX_ROW_BYTES) return MAX_ROW_BYTES;
         return row_bytes_reg;
      endfunction

      function int unsigned image_len();
         if (rows_reg < 1) return 1;
         if (rows_reg > ROWS_LIMIT) return ROWS_LIMIT;
         return rows_reg;
      endfunction

      function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
         int p, pa, pb, pc;
         p  = int'(a) + int'(b) - int'(c);
         pa = p - int'(a);
         pb = p - int'(b);
         pc = p - int'(c);
         if (pa < 0) pa = -pa;
         if (pb < 0) pb = -pb;
         if (pc < 0) pc = -pc;
         if (pa <= pb && pa <= pc) return a;
         if (pb <= pc) return b;
         return c;
      endfunction

      function void take_byte(logic [7:0] x);
         int unsigned      pos;
         logic [7:0]       a, b, c, pred, val;
         logic [8:0]       sum;
         pixel_result_type r;
         if (halted) return;
         if (column == 0) begin
            if (x > FILT_MAX_CODE) begin
               halted = 1'b1;
               r = '{pixel: 8'h00, bad: 1'b1, is_last: 1'b0};
               owed_pixels.insert(owed_pixels.size(), r);
               return;
            end
            row_filter = filter_type'(x[2:0]);
            left_win   = '{default: 8'h00};
            upleft_win = '{default: 8'h00};
            column     = 1;
            return;
         end
         pos = column - 1;
         a = left_win[pixel_bytes() - 1];
         c = first_row ? 8'h00 : upleft_win[pixel_bytes() - 1];
         b = first_row ? 8'h00 : line_buf[pos];
         case (row_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG: begin
               sum  = {1'b0, a} + {1'b0, b};
               pred = sum[8:1];
            end
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'h00;
         endcase
         val = x + pred;
         line_buf[pos] = val;
         for (int k = MAX_BPP - 1; k > 0; k--) begin
            left_win[k]   = left_win[k - 1];
            upleft_win[k] = upleft_win[k - 1];
         end
         left_win[0]   = val;
         upleft_win[0] = b;
         r = '{pixel: val, bad: 1'b0, is_last: 1'b0};
         if (column >= row_len()) begin
            column = 0;
            if (row_idx + 1 >= image_len()) begin
               r.is_last = 1'b1;
               row_idx   = 0;
               first_row = 1'b1;
            end else begin
               row_idx++;
               first_row = 1'b0;
            end
         end else begin
            column++;
         end
         owed_pixels.insert(owed_pixels.size(), r);
      endfunction

      function void check_pixel(logic [7:0] pixel, logic bad, logic is_last);
         pixel_result_type want;
         checked++;
         if (owed_pixels.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding: pixel %02h bad %0b last %0b",
                     $time, pixel, bad, is_last);
            return;
         end
         want = owed_pixels.pop_front();
         if (pixel !== want.pixel) begin
            errors++;
            $display("%0t: pixel_byte expected %02h got %02h", $time, want.pixel, pixel);
         end
         if (bad !== want.bad) begin
            errors++;
            $display("%0t: bad_filter expected %0b got %0b", $time, want.bad, bad);
         end
         if (is_last !== want.is_last) begin
            errors++;
            $display("%0t: last expected %0b got %0b", $time, want.is_last, is_last);
         end
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_pixel_byte;
   logic                  rsp_bad_filter;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   unfilter_scoreboard_type sb = new();

   // run statistics and idling control
   bit quiet_gaps;
   int requests_sent;
   int random_sent;
   int images_done;
   int reg_writes;

   png_scanline_unfilter_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_bad_filter (rsp_bad_filter),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 10 ns clock, starts low
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // gap length for either side, zero throughout a quiet stretch
   function automatic int unsigned pick_gap();
      if (quiet_gaps) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(1, 12);
   endfunction

   // filtered data, leaning on the extremes so that ties and wraps show up
   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one request: optional gap with valid low, then hold valid until taken
   task automatic send_request(logic [7:0] value_in);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value_in;
      do @(posedge clock); while (!req_ready);
      sb.take_byte(value_in);
      requests_sent++;
   endtask

   task automatic send_filter(filter_type f);
      send_request({5'b00000, f});
   endtask

   // drop valid, let every owed pixel come back, then cover the pipe depth
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   // register write, only ever called while no request is in flight
   task automatic csr_write(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mid-image register change; row_bytes only grows while the first row
   // is still being written so that no later row reads an unwritten entry
   task automatic tweak_register();
      csr_index_type idx;
      logic [15:0]   val;
      idx = csr_index_type'($urandom_range(0, 2));
      case (idx)
         CSR_BYTES_PER_PIXEL: val = 16'($urandom_range(0, 7));
         CSR_ROW_BYTES: begin
            if (sb.first_row) val = 16'($urandom_range(0, 12));
            else val = 16'($urandom_range(0, sb.row_len()));
         end
         default: val = 16'($urandom_range(0, 4));
      endcase
      csr_write(idx, val);
   endtask

   // fresh geometry at an image boundary, out-of-range values included
   task automatic new_image_setup();
      logic [15:0] val;
      csr_write(CSR_BYTES_PER_PIXEL, 16'($urandom_range(0, 7)));
      case ($urandom_range(0, 9))
         0:       val = 16'd0;
         1:       val = 16'($urandom_range(13, 48));
         default: val = 16'($urandom_range(1, 12));
      endcase
      csr_write(CSR_ROW_BYTES, val);
      case ($urandom_range(0, 9))
         0:       val = 16'd0;
         1:       val = 16'hFFFF;
         default: val = 16'($urandom_range(1, 4));
      endcase
      csr_write(CSR_IMAGE_ROWS, val);
   endtask

   // response side: random stalls on rsp_ready, one draw per response
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // every response taken is checked against the oldest owed pixel
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel(rsp_pixel_byte, rsp_bad_filter, rsp_last);
   end

   // hang guard, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("png_scanline_unfilter_unit test failed");
      $finish;
   end

   initial begin
      int rows_sent;
      int ignored;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      csr_valid     = 1'b0;
      csr_index     = CSR_BYTES_PER_PIXEL;
      csr_data      = '0;
      quiet_gaps    = 1'b0;
      requests_sent = 0;
      random_sent   = 0;
      images_done   = 0;
      reg_writes    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: widest rows with the reset geometry, unused register index,
      // then a mid-row shrink of row_bytes that cuts the row and the image short
      csr_write(CSR_UNUSED, 16'h1234);
      csr_write(CSR_ROW_BYTES, 16'd16383);
      send_filter(FILT_NONE);
      send_request(8'hFF);
      send_request(8'h00);
      send_request(8'h80);
      send_request(8'h7F);
      send_request(8'h01);
      drain();
      csr_write(CSR_ROW_BYTES, 16'd3);
      send_request(8'hAA);

      // directed: every filter over a five-row image, one byte per pixel
      drain();
      csr_write(CSR_BYTES_PER_PIXEL, 16'd0);
      csr_write(CSR_ROW_BYTES, 16'd2);
      csr_write(CSR_IMAGE_ROWS, 16'd5);
      send_filter(FILT_NONE);
      send_request(8'hFF);
      send_request(8'hFF);
      send_filter(FILT_SUB);
      send_request(8'h01);
      send_request(8'hFF);
      send_filter(FILT_UP);
      send_request(8'hFF);
      send_request(8'h01);
      send_filter(FILT_AVG);
      send_request(8'hFF);
      send_request(8'hFF);
      send_filter(FILT_PAETH);
      send_request(8'h00);
      send_request(8'hFF);
      images_done = 2;

      // random images with random geometry, some mid-image register changes
      while (random_sent < 500) begin
         drain();
         new_image_setup();
         quiet_gaps = ($urandom_range(0, 3) == 0);
         rows_sent  = 0;
         do begin
            if (rows_sent >= 6) begin
               // long image: make this row the last one
               drain();
               csr_write(CSR_IMAGE_ROWS, 16'd1);
            end else if ($urandom_range(0, 7) == 0) begin
               drain();
               tweak_register();
            end
            send_filter(filter_type'($urandom_range(0, 4)));
            random_sent++;
            do begin
               if ($urandom_range(0, 39) == 0) begin
                  drain();
                  tweak_register();
               end
               send_request(pick_data());
               random_sent++;
            end while (sb.column != 0);
            rows_sent++;
         end while (!sb.first_row);
         images_done++;
      end
      quiet_gaps = 1'b0;

      // bad filter code at a row start, then the block should stay silent
      drain();
      send_request(8'($urandom_range(5, 255)));
      ignored = $urandom_range(8, 16);
      repeat (ignored) send_request(8'($urandom_range(0, 255)));
      drain();
      repeat (10) @(negedge clock);

      $display("covered %0d requests over %0d images with %0d register writes",
               requests_sent, images_done, reg_writes);
      $display("checked %0d responses, bad filter halt with %0d ignored requests",
               sb.checked, ignored);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("png_scanline_unfilter_unit test passed");
      end else begin
         $display("png_scanline_unfilter_unit test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/pngu_pkg.sv
hw/rtl/pngu_recon.sv
hw/rtl/png_scanline_unfilter_unit.sv
bench/testbench.sv
